### rtl/hv_pkg.sv
// Shared types and constants of the host name validator.
package hv_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABEL = 2'd1;

    localparam logic [7:0] MAX_TOTAL_RESET = 8'd253;
    localparam logic [6:0] MAX_LABEL_RESET = 7'd63;

    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    localparam logic [8:0] BYTE_COUNT_MAX = 9'd511;
    localparam logic [2:0] QUAD_CNT_MAX = 3'd7;
    localparam logic [2:0] QUAD_PARTS_NEEDED = 3'd3;
    localparam logic [2:0] QUAD_DIGITS_MAX = 3'd3;
    localparam logic [9:0] QUAD_VALUE_SAT = 10'd1023;
    localparam logic [9:0] QUAD_VALUE_MAX = 10'd255;
    localparam logic [7:0] LABEL_COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       final_byte;
    } hv_in_t;

    typedef struct packed {
        logic accepted;
        logic numeric_form;
    } hv_out_t;

    // Byte class as produced by the front end
    typedef struct packed {
        logic       final_byte;
        logic       is_digit;
        logic       is_alnum;
        logic       is_dot;
        logic       is_hyphen;
        logic [3:0] digit;
    } hv_class_t;

    typedef struct packed {
        logic [7:0] max_total_length;
        logic [6:0] max_label_length;
    } hv_cfg_t;

endpackage

### rtl/hostname_validator.sv
// Top level of the streaming host name validator.
//
// Bytes of a host name enter on the in channel, one transaction per byte, with
// final_byte set on the last one. A transaction moves when in_valid is high and
// in_stall is low. Each name yields one transaction on the out channel carrying
// accepted and numeric_form (IPv4 literal versus DNS name).
// Throughput is one byte per cycle while in_stall is low. The final byte is
// written into the classification queue when it is taken; the check logic
// then pops it and loads the output register, unless a verdict still waits
// there under out_stall.
// When the receiver holds out_stall, the verdict waits in the output register
// and bytes of the next name keep flowing through the checks; only a further
// final byte waits, and the queue of QUEUE_DEPTH entries absorbs input until
// it is full, then in_stall rises.
// Limits are written on the cfg channel (index 0: total length, index 1: label
// length); cfg_ready is always high and other indexes are ignored.
// Reset clears the queue, the per-name state and the output valid flag, and
// restores the limits to 253 and 63.
module hostname_validator
    import hv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  hv_in_t                in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hv_out_t               out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    hv_cfg_t   cfg_reg, cfg_next;
    hv_class_t front_cls;
    hv_class_t q_data;
    logic      q_full, q_empty, q_pop, q_push;

    assign cfg_ready = 1'b1;
    assign in_stall = q_full;
    assign q_push = in_valid && !q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_TOTAL: cfg_next.max_total_length = cfg_data;
                CFG_MAX_LABEL: cfg_next.max_label_length = cfg_data[6:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_total_length <= MAX_TOTAL_RESET;
            cfg_reg.max_label_length <= MAX_LABEL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hv_front u_front (
        .in_data (in_data),
        .cls     (front_cls)
    );

    hv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    hv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### rtl/hv_front.sv
// Front end: classifies each incoming byte of the host name.
module hv_front
    import hv_pkg::*;
(
    input  hv_in_t    in_data,
    output hv_class_t cls
);

    logic [7:0] c;
    logic       digit_c;
    logic       alpha_c;
    logic [7:0] digit_off;

    always_comb
    begin
        c = in_data.name_byte;
        digit_c = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        alpha_c = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
                  ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
        digit_off = c - CHAR_ZERO;
        cls.final_byte = in_data.final_byte;
        cls.is_digit = digit_c;
        cls.is_alnum = digit_c | alpha_c;
        cls.is_dot = (c == CHAR_DOT);
        cls.is_hyphen = (c == CHAR_HYPHEN);
        cls.digit = digit_off[3:0];
    end

endmodule

### rtl/hv_fifo.sv
// Short queue of classified bytes between front and back end.
module hv_fifo
    import hv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hv_class_t push_data,
    output logic      full,
    input  logic      pop,
    output hv_class_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hv_class_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/hv_back.sv
// Back end: per-name IPv4 and DNS label checks and the verdict register.
module hv_back
    import hv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hv_cfg_t   cfg,
    input  logic      q_empty,
    input  hv_class_t q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output hv_out_t   out_data
);

    logic [8:0] byte_count_reg, byte_count_next;
    logic       first_ok_reg, first_ok_next;
    logic       digits_dots_reg, digits_dots_next;
    logic [2:0] quad_parts_reg, quad_parts_next;
    logic [2:0] quad_digits_reg, quad_digits_next;
    logic [9:0] quad_value_reg, quad_value_next;
    logic       quad_failed_reg, quad_failed_next;
    logic [7:0] label_count_reg, label_count_next;
    logic       hyphen_reg, hyphen_next;
    logic       label_failed_reg, label_failed_next;

    logic       out_valid_reg, out_valid_next;
    hv_out_t    out_data_reg, out_data_next;

    logic       out_free;
    logic [13:0] quad_prod;
    logic [7:0] label_limit;
    logic       ok_common, ok_quad, ok_label, numeric;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop = !q_empty && (!q_data.final_byte || out_free);
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign label_limit = {1'b0, cfg.max_label_length};

    always_comb
    begin
        byte_count_next = (byte_count_reg == BYTE_COUNT_MAX) ? byte_count_reg
                                                             : byte_count_reg + 1'b1;
        first_ok_next = (byte_count_reg == '0) ? q_data.is_alnum : first_ok_reg;
        digits_dots_next = digits_dots_reg & (q_data.is_digit | q_data.is_dot);

        quad_parts_next = quad_parts_reg;
        quad_digits_next = quad_digits_reg;
        quad_value_next = quad_value_reg;
        quad_failed_next = quad_failed_reg;
        quad_prod = {1'b0, quad_value_reg, 3'b000} + {3'b000, quad_value_reg, 1'b0}
                    + {10'd0, q_data.digit};
        if (q_data.is_dot)
        begin
            if ((quad_digits_reg == '0) || (quad_digits_reg > QUAD_DIGITS_MAX) ||
                (quad_value_reg > QUAD_VALUE_MAX))
            begin
                quad_failed_next = 1'b1;
            end
            if (quad_parts_reg != QUAD_CNT_MAX)
            begin
                quad_parts_next = quad_parts_reg + 1'b1;
            end
            quad_digits_next = '0;
            quad_value_next = '0;
        end
        else if (q_data.is_digit)
        begin
            if (quad_digits_reg != QUAD_CNT_MAX)
            begin
                quad_digits_next = quad_digits_reg + 1'b1;
            end
            quad_value_next = (quad_prod > {4'd0, QUAD_VALUE_SAT}) ? QUAD_VALUE_SAT
                                                                   : quad_prod[9:0];
        end
        else
        begin
            quad_failed_next = 1'b1;
        end

        label_count_next = label_count_reg;
        hyphen_next = hyphen_reg;
        label_failed_next = label_failed_reg;
        if (q_data.is_dot)
        begin
            if ((label_count_reg == '0) || (label_count_reg > label_limit) || hyphen_reg)
            begin
                label_failed_next = 1'b1;
            end
            label_count_next = '0;
            hyphen_next = 1'b0;
        end
        else if (!q_data.is_alnum && !q_data.is_hyphen)
        begin
            label_failed_next = 1'b1;
        end
        else
        begin
            if ((label_count_reg == '0) && q_data.is_hyphen)
            begin
                label_failed_next = 1'b1;
            end
            if (label_count_reg != LABEL_COUNT_MAX)
            begin
                label_count_next = label_count_reg + 1'b1;
            end
            hyphen_next = q_data.is_hyphen;
        end

        // Verdict from the state after this byte
        ok_common = first_ok_next && q_data.is_alnum &&
                    (byte_count_next <= {1'b0, cfg.max_total_length});
        ok_quad = !quad_failed_next && (quad_parts_next == QUAD_PARTS_NEEDED) &&
                  (quad_digits_next != '0) && (quad_digits_next <= QUAD_DIGITS_MAX) &&
                  (quad_value_next <= QUAD_VALUE_MAX);
        ok_label = !label_failed_next && (label_count_next != '0) &&
                   (label_count_next <= label_limit) && !hyphen_next;
        numeric = digits_dots_next;

        out_data_next.accepted = ok_common && (numeric ? ok_quad : ok_label);
        out_data_next.numeric_form = numeric;

        out_valid_next = out_valid_reg && out_stall;
        if (q_pop && q_data.final_byte)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            first_ok_reg <= 1'b0;
            digits_dots_reg <= 1'b1;
            quad_parts_reg <= '0;
            quad_digits_reg <= '0;
            quad_value_reg <= '0;
            quad_failed_reg <= 1'b0;
            label_count_reg <= '0;
            hyphen_reg <= 1'b0;
            label_failed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (q_data.final_byte)
                begin
                    // drop per-name state for the next name
                    byte_count_reg <= '0;
                    first_ok_reg <= 1'b0;
                    digits_dots_reg <= 1'b1;
                    quad_parts_reg <= '0;
                    quad_digits_reg <= '0;
                    quad_value_reg <= '0;
                    quad_failed_reg <= 1'b0;
                    label_count_reg <= '0;
                    hyphen_reg <= 1'b0;
                    label_failed_reg <= 1'b0;
                end
                else
                begin
                    byte_count_reg <= byte_count_next;
                    first_ok_reg <= first_ok_next;
                    digits_dots_reg <= digits_dots_next;
                    quad_parts_reg <= quad_parts_next;
                    quad_digits_reg <= quad_digits_next;
                    quad_value_reg <= quad_value_next;
                    quad_failed_reg <= quad_failed_next;
                    label_count_reg <= label_count_next;
                    hyphen_reg <= hyphen_next;
                    label_failed_reg <= label_failed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.final_byte)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
